@@ hdl/iirl_pkg.sv @@
// Package for the indexed insert/remove list.
// Holds sizing constants, command and status codes, and the cell control and response structs.
// No dependencies.
package iirl_pkg;

  // Sizing of the list.
  localparam int Capacity = 64;
  localparam int WordBits = 32;
  localparam int IdxW     = $clog2(Capacity);
  localparam int CntW     = $clog2(Capacity + 1);

  // Field widths of the channels.
  localparam int KindW   = 3;
  localparam int StatusW = 2;

  // Command codes.
  localparam logic [KindW-1:0] KIND_APPEND = 3'd0;
  localparam logic [KindW-1:0] KIND_INSERT = 3'd1;
  localparam logic [KindW-1:0] KIND_READ   = 3'd2;
  localparam logic [KindW-1:0] KIND_REMOVE = 3'd3;
  localparam logic [KindW-1:0] KIND_CLEAR  = 3'd4;

  // Status codes.
  localparam logic [StatusW-1:0] ST_OK    = 2'd0;
  localparam logic [StatusW-1:0] ST_RANGE = 2'd1;
  localparam logic [StatusW-1:0] ST_FULL  = 2'd2;

  // Broadcast from the controller to every cell.
  typedef struct packed {
    logic                ins;
    logic                rem;
    logic [IdxW-1:0]     pos;
    logic [WordBits-1:0] value;
  } cell_ctrl_t;

  // One response word.
  typedef struct packed {
    logic [WordBits-1:0] read_value;
    logic [CntW-1:0]     length;
    logic [StatusW-1:0]  status;
  } rsp_t;

endpackage

@@ hdl/iirl_cmd_if.sv @@
// Command channel of the indexed insert/remove list.
// Depends on iirl_pkg.
interface iirl_cmd_if;
  logic                         valid;
  logic                         ready;
  logic [iirl_pkg::KindW-1:0]   kind;
  logic [iirl_pkg::IdxW-1:0]    position;
  logic [iirl_pkg::WordBits-1:0] value;

  modport source (output valid, kind, position, value, input ready);
  modport sink   (input valid, kind, position, value, output ready);
endinterface

@@ hdl/iirl_rsp_if.sv @@
// Response channel of the indexed insert/remove list.
// Depends on iirl_pkg.
interface iirl_rsp_if;
  logic                          valid;
  logic                          ready;
  logic [iirl_pkg::WordBits-1:0] read_value;
  logic [iirl_pkg::CntW-1:0]     length;
  logic [iirl_pkg::StatusW-1:0]  status;

  modport source (output valid, read_value, length, status, input ready);
  modport sink   (input valid, read_value, length, status, output ready);
endinterface

@@ hdl/iirl_cell.sv @@
// One storage cell of the list: holds a single word and trades it with its neighbors.
// Depends on iirl_pkg.
module iirl_cell (
  input  logic                          clk_i,
  input  logic [iirl_pkg::IdxW-1:0]     idx_i,
  input  iirl_pkg::cell_ctrl_t          ctrl_i,
  input  logic [iirl_pkg::WordBits-1:0] left_i,
  input  logic [iirl_pkg::WordBits-1:0] right_i,
  output logic [iirl_pkg::WordBits-1:0] word_o,
  output logic [iirl_pkg::WordBits-1:0] sel_o
);

  logic [iirl_pkg::WordBits-1:0] word_q, word_d;

  // Insert moves cells above the slot up and loads the slot; remove pulls cells down.
  always_comb begin
    word_d = word_q;
    if (ctrl_i.ins) begin
      if (idx_i > ctrl_i.pos) begin
        word_d = left_i;
      end else if (idx_i == ctrl_i.pos) begin
        word_d = ctrl_i.value;
      end
    end
    if (ctrl_i.rem && (idx_i >= ctrl_i.pos)) begin
      word_d = right_i;
    end
  end

  always_ff @(posedge clk_i) begin
    word_q <= word_d;
  end

  // The addressed cell drives the shared read bus; all others drive zero.
  assign word_o = word_q;
  assign sel_o  = (idx_i == ctrl_i.pos) ? word_q : '0;

endmodule

@@ hdl/iirl_ctrl.sv @@
// Controller of the indexed insert/remove list: count register, decode and response register.
// Depends on iirl_pkg, iirl_cmd_if and iirl_rsp_if.
module iirl_ctrl (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  iirl_cmd_if.sink                      cmd,
  iirl_rsp_if.source                    rsp,
  input  logic [iirl_pkg::WordBits-1:0] rd_word_i,
  output iirl_pkg::cell_ctrl_t          cell_ctrl_o
);

  logic [iirl_pkg::CntW-1:0] used_q, used_d;
  logic                      rsp_valid_q;
  iirl_pkg::rsp_t            rsp_q, rsp_d;
  logic                      cmd_fire;
  logic                      full;
  logic                      past_end;
  logic                      do_ins;
  logic                      do_rem;

  // A new request enters when the response register is empty or being drained.
  assign cmd.ready = !rsp_valid_q || rsp.ready;
  assign cmd_fire  = cmd.valid && cmd.ready;

  assign full     = (used_q == iirl_pkg::CntW'(iirl_pkg::Capacity));
  assign past_end = (iirl_pkg::CntW'(cmd.position) >= used_q);

  // Decode the request into a cell operation, the next count and the response.
  always_comb begin
    used_d            = used_q;
    do_ins            = 1'b0;
    do_rem            = 1'b0;
    rsp_d.read_value  = '0;
    rsp_d.status      = iirl_pkg::ST_OK;
    cell_ctrl_o.pos   = cmd.position;
    cell_ctrl_o.value = cmd.value;
    case (cmd.kind)
      iirl_pkg::KIND_APPEND, iirl_pkg::KIND_INSERT: begin
        if (full) begin
          rsp_d.status = iirl_pkg::ST_FULL;
        end else begin
          do_ins = 1'b1;
          used_d = used_q + iirl_pkg::CntW'(1);
          // Append, or insert at or past the end, lands in the first free slot.
          if ((cmd.kind == iirl_pkg::KIND_APPEND) || past_end) begin
            cell_ctrl_o.pos = used_q[iirl_pkg::IdxW-1:0];
          end
        end
      end
      iirl_pkg::KIND_READ: begin
        if (past_end) begin
          rsp_d.status = iirl_pkg::ST_RANGE;
        end else begin
          rsp_d.read_value = rd_word_i;
        end
      end
      iirl_pkg::KIND_REMOVE: begin
        if (past_end) begin
          rsp_d.status = iirl_pkg::ST_RANGE;
        end else begin
          do_rem = 1'b1;
          used_d = used_q - iirl_pkg::CntW'(1);
        end
      end
      iirl_pkg::KIND_CLEAR: begin
        used_d = '0;
      end
      default: begin
        used_d = used_q;
      end
    endcase
    rsp_d.length    = used_d;
    cell_ctrl_o.ins = do_ins && cmd_fire;
    cell_ctrl_o.rem = do_rem && cmd_fire;
  end

  // Count and response valid.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      used_q      <= '0;
      rsp_valid_q <= 1'b0;
    end else begin
      if (cmd_fire) begin
        used_q <= used_d;
      end
      if (cmd_fire) begin
        rsp_valid_q <= 1'b1;
      end else if (rsp.ready) begin
        rsp_valid_q <= 1'b0;
      end
    end
  end

  // Response payload.
  always_ff @(posedge clk_i) begin
    if (cmd_fire) begin
      rsp_q <= rsp_d;
    end
  end

  assign rsp.valid      = rsp_valid_q;
  assign rsp.read_value = rsp_q.read_value;
  assign rsp.length     = rsp_q.length;
  assign rsp.status     = rsp_q.status;

  // The count never passes the capacity.
  a_used_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    used_q <= iirl_pkg::CntW'(iirl_pkg::Capacity))
    else $error("count exceeds capacity");

  // A growing request on a full list is refused and leaves the count alone.
  a_full_refused: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_fire && full &&
     ((cmd.kind == iirl_pkg::KIND_APPEND) || (cmd.kind == iirl_pkg::KIND_INSERT)))
    |=> (rsp_q.status == iirl_pkg::ST_FULL) && (used_q == $past(used_q)))
    else $error("full list grew or status missing");

  // Clear empties the list and reports it.
  a_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_fire && (cmd.kind == iirl_pkg::KIND_CLEAR)) |=> (used_q == '0) && (rsp_q.length == '0))
    else $error("clear did not empty the list");

  // The count only moves when a request is taken.
  a_used_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !cmd_fire |=> $stable(used_q))
    else $error("count changed without a request");

  // Cells never shift both ways at once.
  a_one_shift: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(cell_ctrl_o.ins && cell_ctrl_o.rem))
    else $error("insert and remove at once");

endmodule

@@ hdl/indexed_insert_remove_list.sv @@
// Indexed insert/remove list: an ordered list of up to 64 words held in a row of cells.
// Latency: the response is valid on the cycle after the request is taken.
// Throughput: a request per cycle if rsp.ready; insert/remove shift cells in parallel.
// A request is taken whenever the response register is empty or is being drained.
// Reset clears the count and the response valid; stored words are left as they are.
// Depends on iirl_pkg, iirl_cmd_if, iirl_rsp_if, iirl_cell and iirl_ctrl.
module indexed_insert_remove_list (
  input  logic       clk_i,
  input  logic       rst_ni,
  iirl_cmd_if.sink   cmd,
  iirl_rsp_if.source rsp
);

  iirl_pkg::cell_ctrl_t          cell_ctrl;
  logic [iirl_pkg::WordBits-1:0] words [iirl_pkg::Capacity];
  logic [iirl_pkg::WordBits-1:0] sels  [iirl_pkg::Capacity];
  logic [iirl_pkg::WordBits-1:0] rd_word;

  iirl_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd         (cmd),
    .rsp         (rsp),
    .rd_word_i   (rd_word),
    .cell_ctrl_o (cell_ctrl)
  );

  // Row of cells; the ends feed back their own word.
  for (genvar i = 0; i < iirl_pkg::Capacity; i++) begin : g_cell
    iirl_cell u_cell (
      .clk_i   (clk_i),
      .idx_i   (iirl_pkg::IdxW'(i)),
      .ctrl_i  (cell_ctrl),
      .left_i  ((i == 0) ? words[i] : words[(i == 0) ? 0 : i - 1]),
      .right_i ((i == iirl_pkg::Capacity - 1) ? words[i]
                : words[(i == iirl_pkg::Capacity - 1) ? i : i + 1]),
      .word_o  (words[i]),
      .sel_o   (sels[i])
    );
  end

  // Read bus: only the addressed cell drives a nonzero word.
  always_comb begin
    rd_word = '0;
    for (int i = 0; i < iirl_pkg::Capacity; i++) begin
      rd_word = rd_word | sels[i];
    end
  end

endmodule
